FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent assertions with a common error report
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define JTMD_ASSERT(label, clk_in, rst_n, prop) \
	label: assert property (@(posedge clk_in) disable iff (!rst_n) prop) \
		else $error("assertion failed in %m");

// checked at every edge, reset included
`define JTMD_ASSERT_ALWAYS(label, clk_in, prop) \
	label: assert property (@(posedge clk_in) prop) \
		else $error("assertion failed in %m");

`endif

FILE: rtl/jtmd_pkg.sv
// ----------------------------------------------------------------------------
// jtmd_pkg
// types, register indexes and fixed constants of the joystick to motor drive
// ----------------------------------------------------------------------------
package jtmd_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 32;

	localparam int unsigned SAMPLE_FULL = 4095;
	localparam int unsigned REV_SPAN    = 2900;
	localparam int unsigned FWD_SPAN    = SAMPLE_FULL - REV_SPAN;

	typedef logic [SAMPLE_W-1:0] sample_t;

	localparam sample_t THROTTLE_REST = 12'd2900;
	localparam sample_t STEER_CENTER  = 12'd282;

	// register reset values
	localparam sample_t RST_STEER_REST_LOW     = 12'd2800;
	localparam sample_t RST_STEER_REST_HIGH    = 12'd2900;
	localparam sample_t RST_STEER_DUTY_MIN     = 12'd80;
	localparam sample_t RST_STEER_DUTY_MAX     = 12'd493;
	localparam sample_t RST_BRAKE_START        = 12'd700;
	localparam sample_t RST_BRAKE_FULL         = 12'd3500;
	localparam sample_t RST_THROTTLE_REST_LOW  = 12'd2850;
	localparam sample_t RST_THROTTLE_REST_HIGH = 12'd2950;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEER_REST_LOW,
		REG_STEER_REST_HIGH,
		REG_STEER_DUTY_MIN,
		REG_STEER_DUTY_MAX,
		REG_BRAKE_START,
		REG_BRAKE_FULL,
		REG_THROTTLE_REST_LOW,
		REG_THROTTLE_REST_HIGH
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ACT_BRAKE_SCALE,
		ACT_BRAKE_STOP,
		ACT_REST,
		ACT_REVERSE,
		ACT_FORWARD
	} drive_act_t;

	// floor(x / 4095) for x up to 4095 * 4095, by shift-add estimate and one fix-up
	function automatic sample_t div_by_full(input logic [2*SAMPLE_W-1:0] x);
		logic [2*SAMPLE_W:0]   sum;
		logic [SAMPLE_W:0]     q0;
		logic [2*SAMPLE_W+1:0] rem;
		sum = {1'b0, x} + (2*SAMPLE_W+1)'(x[2*SAMPLE_W-1:SAMPLE_W]);
		q0  = sum[2*SAMPLE_W:SAMPLE_W];
		rem = (2*SAMPLE_W+2)'(x) + (2*SAMPLE_W+2)'(q0)
			- (2*SAMPLE_W+2)'({q0, {SAMPLE_W{1'b0}}});
		if (rem >= (2*SAMPLE_W+2)'(SAMPLE_FULL)) begin
			return SAMPLE_W'(q0 + 1'b1);
		end
		return SAMPLE_W'(q0);
	endfunction

endpackage

FILE: rtl/joystick_to_motor_drive.sv
// ----------------------------------------------------------------------------
// joystick_to_motor_drive
// maps steering, throttle and brake samples to servo duty, motor duty and
// h-bridge pins
// ----------------------------------------------------------------------------
// an input transaction passes the input register, the mapping register and the
// result register, in that order, before its result is shown
// throughput: one item per cycle while results are taken; the brake scaling
// loop on the kept duty closes in the result stage (one 12x12 multiply and a
// fixed divide); reset clears the pipeline, the kept duty and the bridge pins
// (braked) and loads the configuration registers with their defaults
module joystick_to_motor_drive #(
	parameter int DUTY_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// steering_sample [11:0], throttle_sample [23:12], brake_sample [35:24]
	input  logic [jtmd_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// steering_duty [11:0], throttle_duty [23:12], bridge_in1 [24], bridge_in2 [25]
	output logic [jtmd_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [jtmd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [jtmd_pkg::SAMPLE_W-1:0]        cfg_data
);
	import jtmd_pkg::*;

	localparam int unsigned DUTY_FULL = (1 << DUTY_BITS) - 1;
	localparam int PROD_W   = SAMPLE_W + DUTY_BITS;
	localparam int RECIP_SH = PROD_W + SAMPLE_W;
	localparam int RECIP_W  = RECIP_SH - 10;
	localparam longint unsigned REV_RECIP_L =
		((64'd1 << RECIP_SH) + 64'(REV_SPAN) - 64'd1) / 64'(REV_SPAN);
	localparam longint unsigned FWD_RECIP_L =
		((64'd1 << RECIP_SH) + 64'(FWD_SPAN) - 64'd1) / 64'(FWD_SPAN);
	localparam logic [RECIP_W-1:0] REV_RECIP = RECIP_W'(REV_RECIP_L);
	localparam logic [RECIP_W-1:0] FWD_RECIP = RECIP_W'(FWD_RECIP_L);

	// configuration
	sample_t steer_rest_low_q, steer_rest_high_q, steer_duty_min_q, steer_duty_max_q;
	sample_t brake_start_q, brake_full_q, throttle_rest_low_q, throttle_rest_high_q;

	// pipeline
	logic       valid_s1, valid_s2, m_valid_q;
	sample_t    steer_s1, throttle_s1, brake_s1;
	sample_t    steer_duty_s2, drive_duty_s2, brake_s2;
	drive_act_t act_s2;
	sample_t    steer_duty_q;

	// kept drive state, also the throttle half of the result
	sample_t kept_duty_q;
	logic    in1_q, in2_q;

	logic out_free, adv2, s2_free, adv1;

	// mapping stage signals
	logic                       steer_at_rest, steer_up;
	sample_t                    steer_span, steer_step, steer_raw, steer_duty;
	logic [2*SAMPLE_W-1:0]      steer_prod;
	logic                       thr_below, thr_above_rest;
	sample_t                    thr_off, drive_duty;
	logic [PROD_W-1:0]          thr_prod;
	logic [RECIP_W-1:0]         thr_recip;
	logic [PROD_W+RECIP_W-1:0]  thr_wide;
	drive_act_t                 act;

	// result stage signals
	logic [2*SAMPLE_W-1:0] brake_prod;
	sample_t               brake_cut, kept_duty_d;
	logic                  in1_d, in2_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_rest_low_q     <= RST_STEER_REST_LOW;
			steer_rest_high_q    <= RST_STEER_REST_HIGH;
			steer_duty_min_q     <= RST_STEER_DUTY_MIN;
			steer_duty_max_q     <= RST_STEER_DUTY_MAX;
			brake_start_q        <= RST_BRAKE_START;
			brake_full_q         <= RST_BRAKE_FULL;
			throttle_rest_low_q  <= RST_THROTTLE_REST_LOW;
			throttle_rest_high_q <= RST_THROTTLE_REST_HIGH;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_STEER_REST_LOW:     steer_rest_low_q     <= cfg_data;
				REG_STEER_REST_HIGH:    steer_rest_high_q    <= cfg_data;
				REG_STEER_DUTY_MIN:     steer_duty_min_q     <= cfg_data;
				REG_STEER_DUTY_MAX:     steer_duty_max_q     <= cfg_data;
				REG_BRAKE_START:        brake_start_q        <= cfg_data;
				REG_BRAKE_FULL:         brake_full_q         <= cfg_data;
				REG_THROTTLE_REST_LOW:  throttle_rest_low_q  <= cfg_data;
				REG_THROTTLE_REST_HIGH: throttle_rest_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// elastic handshake: each stage moves when the one after it has room
	assign out_free = !m_valid_q || m_tready;
	assign adv2     = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || adv2;
	assign adv1     = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_free) begin
				m_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			steer_s1    <= s_tdata[SAMPLE_W-1:0];
			throttle_s1 <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
			brake_s1    <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
		end
	end

	// steering map
	always_comb begin
		steer_at_rest = (steer_s1 > steer_rest_low_q) && (steer_s1 < steer_rest_high_q);
		steer_up      = steer_duty_max_q >= steer_duty_min_q;
		steer_span    = steer_up ? steer_duty_max_q - steer_duty_min_q
		                         : steer_duty_min_q - steer_duty_max_q;
		steer_prod    = steer_s1 * steer_span;
		steer_step    = div_by_full(steer_prod);
		if (steer_at_rest) begin
			steer_raw = STEER_CENTER;
		end else if (steer_up) begin
			steer_raw = steer_duty_min_q + steer_step;
		end else begin
			steer_raw = steer_duty_min_q - steer_step;
		end
		steer_duty = (32'(steer_raw) > DUTY_FULL) ? SAMPLE_W'(DUTY_FULL) : steer_raw;
	end

	// throttle map (|t - rest| * full scale * span reciprocal) and drive action
	always_comb begin
		thr_above_rest = throttle_s1 > THROTTLE_REST;
		thr_below      = throttle_s1 < throttle_rest_low_q;
		thr_off        = thr_above_rest ? throttle_s1 - THROTTLE_REST
		                                : THROTTLE_REST - throttle_s1;
		thr_prod       = PROD_W'({thr_off, {DUTY_BITS{1'b0}}}) - PROD_W'(thr_off);
		thr_recip      = thr_below ? REV_RECIP : FWD_RECIP;
		thr_wide       = (PROD_W+RECIP_W)'(thr_prod) * (PROD_W+RECIP_W)'(thr_recip);
		if (thr_below || thr_above_rest) begin
			drive_duty = SAMPLE_W'(thr_wide[RECIP_SH +: DUTY_BITS]);
		end else begin
			drive_duty = '0;
		end

		if (brake_s1 > brake_start_q) begin
			act = (brake_s1 > brake_full_q) ? ACT_BRAKE_STOP : ACT_BRAKE_SCALE;
		end else if (throttle_s1 >= throttle_rest_low_q
			&& throttle_s1 <= throttle_rest_high_q) begin
			act = ACT_REST;
		end else if (thr_below) begin
			act = ACT_REVERSE;
		end else begin
			act = ACT_FORWARD;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			steer_duty_s2 <= steer_duty;
			drive_duty_s2 <= drive_duty;
			brake_s2      <= brake_s1;
			act_s2        <= act;
		end
	end

	// result stage: update of the kept duty and bridge pins
	always_comb begin
		brake_prod  = brake_s2 * kept_duty_q;
		brake_cut   = div_by_full(brake_prod);
		kept_duty_d = kept_duty_q;
		in1_d       = in1_q;
		in2_d       = in2_q;
		case (act_s2)
			ACT_BRAKE_SCALE: begin
				kept_duty_d = kept_duty_q - brake_cut;
			end
			ACT_BRAKE_STOP, ACT_REST: begin
				kept_duty_d = '0;
				in1_d       = 1'b0;
				in2_d       = 1'b0;
			end
			ACT_REVERSE: begin
				kept_duty_d = drive_duty_s2;
				in1_d       = 1'b0;
				in2_d       = 1'b1;
			end
			ACT_FORWARD: begin
				kept_duty_d = drive_duty_s2;
				in1_d       = 1'b1;
				in2_d       = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_duty_q <= '0;
			in1_q       <= 1'b0;
			in2_q       <= 1'b0;
		end else if (adv2) begin
			kept_duty_q <= kept_duty_d;
			in1_q       <= in1_d;
			in2_q       <= in2_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			steer_duty_q <= steer_duty_s2;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(OUT_TDATA_W-2*SAMPLE_W-2)'(0), in2_q, in1_q, kept_duty_q, steer_duty_q};

endmodule

FILE: rtl/jtmd_checker.sv
// ----------------------------------------------------------------------------
// jtmd_checker
// port-level checks of the joystick to motor drive, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jtmd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic [jtmd_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tvalid,
	input logic                             m_tready
);

	// a stalled result transaction holds
	`JTMD_ASSERT(a_out_valid_holds, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid)
	`JTMD_ASSERT(a_out_data_holds, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata))

	// the bridge is never driven both ways
	`JTMD_ASSERT_ALWAYS(a_pins_exclusive, clk, m_tvalid |-> !(m_tdata[24] && m_tdata[25]))

	// braked bridge always goes with zero motor duty
	`JTMD_ASSERT(a_braked_no_duty, clk, arst_n,
		m_tvalid && !m_tdata[24] && !m_tdata[25] |-> m_tdata[23:12] == 12'd0)

	// with the result side draining, input is never held off
	`JTMD_ASSERT(a_no_stall_when_drained, clk, arst_n, m_tready |-> s_tready)

endmodule

bind joystick_to_motor_drive jtmd_checker u_jtmd_checker (.*);

FILE: bench/joystick_to_motor_drive_tb.sv
// ----------------------------------------------------------------------------
// joystick_to_motor_drive_tb
// streams steering, throttle and brake samples through the drive mapper under
// several register settings, predicts every duty and bridge result in a
// scoreboard and compares the output stream field by field, with bursty input
// and a stalling output side
// ----------------------------------------------------------------------------
module joystick_to_motor_drive_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import jtmd_pkg::*;

	localparam int DUTY_BITS = 12;
	localparam int NUM_REGS = 8;
	localparam int ITEMS_PER_PHASE = 225;
	localparam int HOLD_CYCLES = 80;

	typedef sample_t reg_set_t [NUM_REGS];

	typedef struct packed {
		sample_t steer_duty;
		sample_t motor_duty;
		logic    in1;
		logic    in2;
	} drive_result_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_PERIODIC
	} rx_style_t;

	class drive_check;
		sample_t       regs [NUM_REGS];
		sample_t       kept_duty;
		logic [1:0]    pins;	// in1, in2
		drive_result_t expected_drives [$];
		int            failures;

		function new();
			regs[REG_STEER_REST_LOW]     = RST_STEER_REST_LOW;
			regs[REG_STEER_REST_HIGH]    = RST_STEER_REST_HIGH;
			regs[REG_STEER_DUTY_MIN]     = RST_STEER_DUTY_MIN;
			regs[REG_STEER_DUTY_MAX]     = RST_STEER_DUTY_MAX;
			regs[REG_BRAKE_START]        = RST_BRAKE_START;
			regs[REG_BRAKE_FULL]         = RST_BRAKE_FULL;
			regs[REG_THROTTLE_REST_LOW]  = RST_THROTTLE_REST_LOW;
			regs[REG_THROTTLE_REST_HIGH] = RST_THROTTLE_REST_HIGH;
			kept_duty = '0;
			pins      = 2'b00;
			failures  = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, sample_t val);
			regs[idx] = val;
		endfunction

		function int pending();
			return expected_drives.size();
		endfunction

		function sample_t clamp_duty(int unsigned d);
			int unsigned full;
			full = (1 << DUTY_BITS) - 1;
			return sample_t'(d > full ? full : d);
		endfunction

		function sample_t steer_duty_for(sample_t s);
			int unsigned lo, hi, sv, d;
			lo = regs[REG_STEER_DUTY_MIN];
			hi = regs[REG_STEER_DUTY_MAX];
			sv = s;
			if (s > regs[REG_STEER_REST_LOW] && s < regs[REG_STEER_REST_HIGH]) begin
				return clamp_duty(STEER_CENTER);
			end
			if (hi >= lo) begin
				d = lo + (sv * (hi - lo)) / SAMPLE_FULL;
			end else begin
				d = lo - (sv * (lo - hi)) / SAMPLE_FULL;
			end
			return clamp_duty(d);
		endfunction

		// brake first, then rest window, then reverse, then forward
		function void advance_drive(sample_t t, sample_t b);
			int unsigned d, tv, bv, off, full;
			full = (1 << DUTY_BITS) - 1;
			d  = kept_duty;
			tv = t;
			bv = b;
			if (b > regs[REG_BRAKE_START]) begin
				d = d - (bv * d) / SAMPLE_FULL;
				if (b > regs[REG_BRAKE_FULL]) begin
					d    = 0;
					pins = 2'b00;
				end
			end else if (t >= regs[REG_THROTTLE_REST_LOW]
					&& t <= regs[REG_THROTTLE_REST_HIGH]) begin
				d    = 0;
				pins = 2'b00;
			end else if (t < regs[REG_THROTTLE_REST_LOW]) begin
				off  = (tv > REV_SPAN) ? tv - REV_SPAN : REV_SPAN - tv;
				d    = (off * full) / REV_SPAN;
				pins = 2'b01;
			end else begin
				d    = (tv > REV_SPAN) ? ((tv - REV_SPAN) * full) / FWD_SPAN : 0;
				pins = 2'b10;
			end
			kept_duty = clamp_duty(d);
		endfunction

		function void note_sample(sample_t s, sample_t t, sample_t b);
			drive_result_t r;
			r.steer_duty = steer_duty_for(s);
			advance_drive(t, b);
			r.motor_duty = kept_duty;
			r.in1        = pins[1];
			r.in2        = pins[0];
			expected_drives.push_back(r);
		endfunction

		function void check_drive(logic [OUT_TDATA_W-1:0] data);
			drive_result_t want, got;
			got.steer_duty = data[11:0];
			got.motor_duty = data[23:12];
			got.in1        = data[24];
			got.in2        = data[25];
			if (expected_drives.size() == 0) begin
				if (failures < 10) begin
					$display("unexpected result transaction: ",
						"steer %0d motor %0d in1 %b in2 %b",
						got.steer_duty, got.motor_duty, got.in1, got.in2);
				end
				failures++;
				return;
			end
			want = expected_drives.pop_front();
			if (got.steer_duty !== want.steer_duty || got.motor_duty !== want.motor_duty
					|| got.in1 !== want.in1 || got.in2 !== want.in2) begin
				if (failures < 10) begin
					$display("mismatch: expected steer %0d motor %0d in1 %b in2 %b,",
						want.steer_duty, want.motor_duty, want.in1, want.in2,
						" got steer %0d motor %0d in1 %b in2 %b",
						got.steer_duty, got.motor_duty, got.in1, got.in2);
				end
				failures++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	sample_t                cfg_data = '0;

	drive_check sb;
	int         burst_left = 0;

	// receiver stall control
	int        hold_asked = 0;
	int        hold_served = 0;
	int        hold_left = 0;
	rx_style_t rx_style = RX_OPEN;
	int        style_left = 0;
	int        rx_tick = 0;

	joystick_to_motor_drive #(
		.DUTY_BITS(DUTY_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_asked;
			hold_left   <= HOLD_CYCLES;
			m_tready    <= 1'b0;
		end else begin
			if (style_left == 0) begin
				rx_style   <= rx_style_t'($urandom_range(0, 2));
				style_left <= $urandom_range(50, 300);
			end else begin
				style_left <= style_left - 1;
			end
			case (rx_style)
				RX_OPEN:     m_tready <= 1'b1;
				RX_RANDOM:   m_tready <= $urandom_range(0, 1);
				RX_PERIODIC: m_tready <= (rx_tick % 5) < 2;
				default:     m_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_drive(m_tdata);
		end
	end

	task automatic offer_samples(input sample_t s, input sample_t t, input sample_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tdata  <= IN_TDATA_W'({b, t, s});
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(s, t, b);
		burst_left--;
	endtask

	task automatic write_config(input reg_set_t vals);
		cfg_reg_t idx;
		for (int i = 0; i < NUM_REGS; i++) begin
			idx = cfg_reg_t'(i);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			sb.set_reg(idx, vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic sample_t pick_near(int unsigned v);
		int x;
		x = int'(v) + int'($urandom_range(0, 6)) - 3;
		if (x < 0) x = 0;
		if (x > int'(SAMPLE_FULL)) x = SAMPLE_FULL;
		return sample_t'(x);
	endfunction

	function automatic sample_t pick_steering();
		case ($urandom_range(0, 9))
			5, 6:    return pick_near(sb.regs[REG_STEER_REST_LOW]);
			7:       return pick_near(sb.regs[REG_STEER_REST_HIGH]);
			8:       return '0;
			9:       return sample_t'(SAMPLE_FULL);
			default: return sample_t'($urandom_range(0, SAMPLE_FULL));
		endcase
	endfunction

	function automatic sample_t pick_throttle();
		case ($urandom_range(0, 9))
			4:       return pick_near(sb.regs[REG_THROTTLE_REST_LOW]);
			5:       return pick_near(sb.regs[REG_THROTTLE_REST_HIGH]);
			6:       return pick_near(THROTTLE_REST);
			// the stretches between a window edge and the fixed rest point
			7:       return sample_t'($urandom_range(sb.regs[REG_THROTTLE_REST_HIGH],
						REV_SPAN));
			8:       return sample_t'($urandom_range(REV_SPAN,
						sb.regs[REG_THROTTLE_REST_LOW]));
			9:       return $urandom_range(0, 1) ? sample_t'(SAMPLE_FULL) : '0;
			default: return sample_t'($urandom_range(0, SAMPLE_FULL));
		endcase
	endfunction

	// mostly released so the throttle charges the kept duty between brakes
	function automatic sample_t pick_brake();
		case ($urandom_range(0, 9))
			5, 6:    return pick_near(sb.regs[REG_BRAKE_START]);
			7:       return sample_t'($urandom_range(sb.regs[REG_BRAKE_START],
						sb.regs[REG_BRAKE_FULL]));
			8:       return pick_near(sb.regs[REG_BRAKE_FULL]);
			9:       return sample_t'($urandom_range(0, SAMPLE_FULL));
			default: return sample_t'($urandom_range(0, sb.regs[REG_BRAKE_START]));
		endcase
	endfunction

	initial begin
		reg_set_t plans [8];
		reg_set_t rnd;

		sb = new();
		plans[0] = '{RST_STEER_REST_LOW, RST_STEER_REST_HIGH, RST_STEER_DUTY_MIN,
			RST_STEER_DUTY_MAX, RST_BRAKE_START, RST_BRAKE_FULL,
			RST_THROTTLE_REST_LOW, RST_THROTTLE_REST_HIGH};
		plans[1] = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
		plans[2] = '{12'd4095, 12'd4095, 12'd4095, 12'd4095,
			12'd4095, 12'd4095, 12'd4095, 12'd4095};
		// crossed windows, downward steering, full level below start level
		plans[3] = '{12'd3000, 12'd1000, 12'd4095, 12'd0,
			12'd2000, 12'd1000, 12'd3000, 12'd2800};
		// throttle window above the rest point, reverse from above it
		plans[4] = '{12'd100, 12'd4000, 12'd493, 12'd80,
			12'd700, 12'd3500, 12'd3100, 12'd3200};
		// throttle window below the rest point, forward saturating at zero
		plans[5] = '{12'd2800, 12'd2900, 12'd0, 12'd4095,
			12'd0, 12'd4095, 12'd2600, 12'd2700};
		for (int i = 0; i < NUM_REGS; i++)
			rnd[i] = sample_t'($urandom_range(0, SAMPLE_FULL));
		plans[6] = rnd;
		plans[7] = plans[0];

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: field extremes and every drive action
		offer_samples(12'd0, 12'd0, 12'd0);
		offer_samples(12'd4095, 12'd4095, 12'd0);
		offer_samples(12'd2850, 12'd2900, 12'd0);
		offer_samples(12'd2800, 12'd3500, 12'd0);
		offer_samples(12'd2900, 12'd2000, 12'd700);
		offer_samples(12'd2801, 12'd2000, 12'd701);
		offer_samples(12'd2899, 12'd2000, 12'd3500);
		offer_samples(12'd1000, 12'd4095, 12'd0);
		offer_samples(12'd1000, 12'd4095, 12'd4095);
		offer_samples(12'd2048, 12'd2849, 12'd0);
		offer_samples(12'd2048, 12'd2951, 12'd0);
		offer_samples(12'd2048, 12'd2950, 12'd0);
		offer_samples(12'd2048, 12'd4095, 12'd0);
		offer_samples(12'd2048, 12'd0, 12'd2000);
		offer_samples(12'd4095, 12'd4095, 12'd3501);
		offer_samples(12'd4095, 12'd2850, 12'd4095);

		for (int p = 0; p < 8; p++) begin
			if (p != 0) begin
				wait_drained();
				write_config(plans[p]);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// one long output hold-off while input keeps coming
				if (p == 1 && n == 40) begin
					hold_asked <= hold_asked + 1;
					burst_left = HOLD_CYCLES + 40;
				end
				offer_samples(pick_steering(), pick_throttle(), pick_brake());
			end
		end

		wait_drained();
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("joystick_to_motor_drive verification clean");
		end else begin
			$display("joystick_to_motor_drive verification failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("joystick_to_motor_drive verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/jtmd_pkg.sv
rtl/joystick_to_motor_drive.sv
rtl/jtmd_checker.sv
bench/joystick_to_motor_drive_tb.sv
